FILE: hdl/net_hpwl_bound_reducer_defines.svh
// Assertion helpers for the net wirelength blocks.
`ifndef NET_HPWL_BOUND_REDUCER_DEFINES_SVH
`define NET_HPWL_BOUND_REDUCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NHBR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nhbr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NHBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nhbr assertion failed");

`endif

FILE: hdl/nhbr_pkg.sv
`default_nettype none

package nhbr_pkg;

   localparam int PIN_W     = 32;
   localparam int HALF_W    = 30;
   localparam int COMP_W    = 16;
   localparam int WEIGHT_W  = 16;
   localparam int MODE_W    = 2;
   localparam int IDX_W     = 8;
   localparam int COUNT_W   = 9;
   localparam int WL_W      = 48;
   localparam int WL_SUM_W  = 49;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_MAX_PINS   = 256;
   localparam int DEF_COORD_BITS = 32;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 1'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_PIN     = 2'd0,
      MODE_BBOX    = 2'd1,
      MODE_CENTER  = 2'd2,
      MODE_EXCLUDE = 2'd3
   } mode_type;

   // Per-net bookkeeping that rides along with the bounds.
   typedef struct packed {
      logic [IDX_W-1:0]   max_x;
      logic [IDX_W-1:0]   min_x;
      logic [IDX_W-1:0]   max_y;
      logic [IDX_W-1:0]   min_y;
      logic [COUNT_W-1:0] count;
      logic               use_span;
   } tag_type;

endpackage

`default_nettype wire

FILE: hdl/nhbr_accum.sv
`default_nettype none

`include "net_hpwl_bound_reducer_defines.svh"

module nhbr_accum import nhbr_pkg::*; #(
   parameter int MAX_PINS   = DEF_MAX_PINS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mode_type                     mode,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [PIN_W-1:0]      pin_x,
   input  wire logic signed [PIN_W-1:0]      pin_y,
   input  wire logic [HALF_W-1:0]            pin_half_w,
   input  wire logic [HALF_W-1:0]            pin_half_h,
   input  wire logic [COMP_W-1:0]            component_id,
   input  wire logic [COMP_W-1:0]            exclude_id,
   input  wire logic                         last,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [COORD_BITS-1:0]      out_lo_x,
   output logic signed [COORD_BITS-1:0]      out_hi_x,
   output logic signed [COORD_BITS-1:0]      out_lo_y,
   output logic signed [COORD_BITS-1:0]      out_hi_y,
   output tag_type                           out_tag
);

   localparam int CNT_W = $clog2(MAX_PINS + 1);
   localparam int EXT_W = (COORD_BITS > 33) ? COORD_BITS + 1 : 34;

   localparam logic signed [EXT_W-1:0] EXT_MAX =
      signed'({{(EXT_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}});
   localparam logic signed [EXT_W-1:0] EXT_MIN = ~EXT_MAX;
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = ~C_MAX;
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PINS);
   localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(MAX_PINS - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   function automatic logic signed [COORD_BITS-1:0] sat_ext(
      input logic signed [EXT_W-1:0] v
   );
      logic signed [COORD_BITS-1:0] r;
      if (v > EXT_MAX) begin
         r = C_MAX;
      end else if (v < EXT_MIN) begin
         r = C_MIN;
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // pin stage: extents already saturated
   logic                         a_valid_ff;
   logic signed [COORD_BITS-1:0] a_lx_ff, a_hx_ff, a_ly_ff, a_hy_ff;
   logic                         a_keep_ff;
   logic                         a_last_ff;

   // running extremes of the current net
   logic signed [COORD_BITS-1:0] run_min_x_ff, run_max_x_ff, run_min_y_ff, run_max_y_ff;
   logic signed [COORD_BITS-1:0] run_min_x_in, run_max_x_in, run_min_y_in, run_max_y_in;
   logic [IDX_W-1:0]             idx_max_x_ff, idx_min_x_ff, idx_max_y_ff, idx_min_y_ff;
   logic [IDX_W-1:0]             idx_max_x_in, idx_min_x_in, idx_max_y_in, idx_min_y_in;
   logic [CNT_W-1:0]             pins_seen_ff, pins_seen_in;
   logic                         kept_any_ff, kept_any_in;

   // end-of-net record
   logic                         b_valid_ff;
   logic signed [COORD_BITS-1:0] b_lo_x_ff, b_hi_x_ff, b_lo_y_ff, b_hi_y_ff;
   logic signed [COORD_BITS-1:0] b_lo_x_in, b_hi_x_in, b_lo_y_in, b_hi_y_in;
   tag_type                      b_tag_ff, b_tag_in;

   logic signed [EXT_W-1:0] x_w, y_w, hw_w, hh_w;
   logic                    in_take, a_go, b_ready, keep_in;
   logic [CNT_W-1:0]        pos;
   logic [IDX_W-1:0]        pos_idx;
   logic                    single, sentinel;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_go     = a_valid_ff && (!a_last_ff || b_ready);
   assign in_ready = !a_valid_ff || a_go;
   assign in_take  = in_valid && in_ready;

   always_comb begin
      x_w     = EXT_W'(pin_x);
      y_w     = EXT_W'(pin_y);
      hw_w    = (mode == MODE_BBOX) ? signed'(EXT_W'(pin_half_w)) : '0;
      hh_w    = (mode == MODE_BBOX) ? signed'(EXT_W'(pin_half_h)) : '0;
      keep_in = (mode != MODE_EXCLUDE) || (component_id != exclude_id);
   end

   always_comb begin
      pos     = (pins_seen_ff < CNT_MAX) ? pins_seen_ff : POS_LAST;
      pos_idx = IDX_W'(pos);

      run_min_x_in = run_min_x_ff;
      run_max_x_in = run_max_x_ff;
      run_min_y_in = run_min_y_ff;
      run_max_y_in = run_max_y_ff;
      idx_max_x_in = idx_max_x_ff;
      idx_min_x_in = idx_min_x_ff;
      idx_max_y_in = idx_max_y_ff;
      idx_min_y_in = idx_min_y_ff;
      kept_any_in  = kept_any_ff;
      pins_seen_in = (pins_seen_ff < CNT_MAX) ? pins_seen_ff + CNT_ONE : pins_seen_ff;

      if (a_keep_ff) begin
         kept_any_in = 1'b1;
         if (!kept_any_ff) begin
            run_min_x_in = a_lx_ff;
            run_max_x_in = a_hx_ff;
            run_min_y_in = a_ly_ff;
            run_max_y_in = a_hy_ff;
            idx_max_x_in = pos_idx;
            idx_min_x_in = pos_idx;
            idx_max_y_in = pos_idx;
            idx_min_y_in = pos_idx;
         end else begin
            // strict compares: the first pin at an extreme keeps it
            if (a_hx_ff > run_max_x_ff) begin
               run_max_x_in = a_hx_ff;
               idx_max_x_in = pos_idx;
            end
            if (a_lx_ff < run_min_x_ff) begin
               run_min_x_in = a_lx_ff;
               idx_min_x_in = pos_idx;
            end
            if (a_hy_ff > run_max_y_ff) begin
               run_max_y_in = a_hy_ff;
               idx_max_y_in = pos_idx;
            end
            if (a_ly_ff < run_min_y_ff) begin
               run_min_y_in = a_ly_ff;
               idx_min_y_in = pos_idx;
            end
         end
      end

      single   = (pins_seen_in == CNT_ONE);
      sentinel = !kept_any_in || ((mode == MODE_EXCLUDE) && single);

      b_tag_in          = '0;
      b_tag_in.count    = COUNT_W'(pins_seen_in);
      b_tag_in.use_span = !sentinel && !single;
      if (sentinel) begin
         b_lo_x_in = C_MIN;
         b_hi_x_in = C_MAX;
         b_lo_y_in = C_MIN;
         b_hi_y_in = C_MAX;
      end else begin
         b_lo_x_in = run_min_x_in;
         b_hi_x_in = run_max_x_in;
         b_lo_y_in = run_min_y_in;
         b_hi_y_in = run_max_y_in;
      end
      if (b_tag_in.use_span) begin
         b_tag_in.max_x = idx_max_x_in;
         b_tag_in.min_x = idx_min_x_in;
         b_tag_in.max_y = idx_max_y_in;
         b_tag_in.min_y = idx_min_y_in;
         // pin mode: flat axis reports max at 0, min at 1
         if ((mode == MODE_PIN) && (run_min_x_in == run_max_x_in)) begin
            b_tag_in.max_x = IDX_W'(0);
            b_tag_in.min_x = IDX_W'(1);
         end
         if ((mode == MODE_PIN) && (run_min_y_in == run_max_y_in)) begin
            b_tag_in.max_y = IDX_W'(0);
            b_tag_in.min_y = IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         run_min_x_ff <= '0;
         run_max_x_ff <= '0;
         run_min_y_ff <= '0;
         run_max_y_ff <= '0;
         idx_max_x_ff <= '0;
         idx_min_x_ff <= '0;
         idx_max_y_ff <= '0;
         idx_min_y_ff <= '0;
         pins_seen_ff <= '0;
         kept_any_ff  <= 1'b0;
      end else begin
         if (in_take) begin
            a_valid_ff <= 1'b1;
         end else if (a_go) begin
            a_valid_ff <= 1'b0;
         end

         if (a_go && a_last_ff) begin
            b_valid_ff <= 1'b1;
         end else if (out_ready) begin
            b_valid_ff <= 1'b0;
         end

         if (a_go) begin
            if (a_last_ff) begin
               run_min_x_ff <= '0;
               run_max_x_ff <= '0;
               run_min_y_ff <= '0;
               run_max_y_ff <= '0;
               idx_max_x_ff <= '0;
               idx_min_x_ff <= '0;
               idx_max_y_ff <= '0;
               idx_min_y_ff <= '0;
               pins_seen_ff <= '0;
               kept_any_ff  <= 1'b0;
            end else begin
               run_min_x_ff <= run_min_x_in;
               run_max_x_ff <= run_max_x_in;
               run_min_y_ff <= run_min_y_in;
               run_max_y_ff <= run_max_y_in;
               idx_max_x_ff <= idx_max_x_in;
               idx_min_x_ff <= idx_min_x_in;
               idx_max_y_ff <= idx_max_y_in;
               idx_min_y_ff <= idx_min_y_in;
               pins_seen_ff <= pins_seen_in;
               kept_any_ff  <= kept_any_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         a_lx_ff   <= sat_ext(x_w - hw_w);
         a_hx_ff   <= sat_ext(x_w + hw_w);
         a_ly_ff   <= sat_ext(y_w - hh_w);
         a_hy_ff   <= sat_ext(y_w + hh_w);
         a_keep_ff <= keep_in;
         a_last_ff <= last;
      end
      if (a_go && a_last_ff) begin
         b_lo_x_ff <= b_lo_x_in;
         b_hi_x_ff <= b_hi_x_in;
         b_lo_y_ff <= b_lo_y_in;
         b_hi_y_ff <= b_hi_y_in;
         b_tag_ff  <= b_tag_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_lo_x  = b_lo_x_ff;
   assign out_hi_x  = b_hi_x_ff;
   assign out_lo_y  = b_lo_y_ff;
   assign out_hi_y  = b_hi_y_ff;
   assign out_tag   = b_tag_ff;

   `NHBR_ASSERT_NOW(a_run_order, clock, reset, kept_any_ff,
      (run_min_x_ff <= run_max_x_ff) && (run_min_y_ff <= run_max_y_ff))
   `NHBR_ASSERT_NOW(a_run_idle_clear, clock, reset, !kept_any_ff,
      (run_min_x_ff == '0) && (run_max_x_ff == '0) && (idx_max_x_ff == '0) &&
      (idx_min_y_ff == '0))
   `NHBR_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, pins_seen_ff <= CNT_MAX)
   `NHBR_ASSERT_NOW(a_end_span_order, clock, reset, b_valid_ff && b_tag_ff.use_span,
      (b_lo_x_ff <= b_hi_x_ff) && (b_lo_y_ff <= b_hi_y_ff))
   `NHBR_ASSERT_NEXT(a_net_clear, clock, reset, a_go && a_last_ff,
      (pins_seen_ff == '0) && !kept_any_ff)

endmodule

`default_nettype wire

FILE: hdl/nhbr_weigh.sv
`default_nettype none

module nhbr_weigh import nhbr_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [WEIGHT_W-1:0]          weight,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [COORD_BITS-1:0] in_lo_x,
   input  wire logic signed [COORD_BITS-1:0] in_hi_x,
   input  wire logic signed [COORD_BITS-1:0] in_lo_y,
   input  wire logic signed [COORD_BITS-1:0] in_hi_y,
   input  wire tag_type                      in_tag,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [PIN_W-1:0]           rsp_x_lo,
   output logic signed [PIN_W-1:0]           rsp_x_hi,
   output logic signed [PIN_W-1:0]           rsp_y_lo,
   output logic signed [PIN_W-1:0]           rsp_y_hi,
   output logic [WL_W-1:0]                   rsp_wl_x,
   output logic [WL_W-1:0]                   rsp_wl_y,
   output logic [WL_SUM_W-1:0]               rsp_wl_total,
   output logic [IDX_W-1:0]                  rsp_max_x_index,
   output logic [IDX_W-1:0]                  rsp_min_x_index,
   output logic [IDX_W-1:0]                  rsp_max_y_index,
   output logic [IDX_W-1:0]                  rsp_min_y_index,
   output logic [COUNT_W-1:0]                rsp_pin_count
);

   localparam int MUL_W = (COORD_BITS + WEIGHT_W > WL_W) ? COORD_BITS + WEIGHT_W : WL_W + 1;

   // span stage
   logic                         c_valid_ff;
   logic [COORD_BITS-1:0]        c_span_x_ff, c_span_y_ff;
   logic signed [PIN_W-1:0]      c_x_lo_ff, c_x_hi_ff, c_y_lo_ff, c_y_hi_ff;
   tag_type                      c_tag_ff;
   // product stage
   logic                         d_valid_ff;
   logic [WL_W-1:0]              d_wl_x_ff, d_wl_y_ff;
   logic signed [PIN_W-1:0]      d_x_lo_ff, d_x_hi_ff, d_y_lo_ff, d_y_hi_ff;
   tag_type                      d_tag_ff;
   // output stage
   logic                         e_valid_ff;
   logic [WL_W-1:0]              e_wl_x_ff, e_wl_y_ff;
   logic [WL_SUM_W-1:0]          e_wl_total_ff;
   logic signed [PIN_W-1:0]      e_x_lo_ff, e_x_hi_ff, e_y_lo_ff, e_y_hi_ff;
   tag_type                      e_tag_ff;

   logic                 c_ready, d_ready, e_ready;
   logic [COORD_BITS-1:0] span_x_in, span_y_in;
   logic [MUL_W-1:0]     prod_x, prod_y;
   logic [WL_W-1:0]      wl_x_in, wl_y_in;

   assign e_ready  = !e_valid_ff || rsp_ready;
   assign d_ready  = !d_valid_ff || e_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   // hi >= lo whenever the span is used, so the difference fits unsigned
   assign span_x_in = in_tag.use_span ? COORD_BITS'(in_hi_x - in_lo_x) : '0;
   assign span_y_in = in_tag.use_span ? COORD_BITS'(in_hi_y - in_lo_y) : '0;

   always_comb begin
      prod_x  = MUL_W'(c_span_x_ff) * MUL_W'(weight);
      prod_y  = MUL_W'(c_span_y_ff) * MUL_W'(weight);
      wl_x_in = (|prod_x[MUL_W-1:WL_W]) ? '1 : prod_x[WL_W-1:0];
      wl_y_in = (|prod_y[MUL_W-1:WL_W]) ? '1 : prod_y[WL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (c_ready) begin
            c_valid_ff <= in_valid;
         end
         if (d_ready) begin
            d_valid_ff <= c_valid_ff;
         end
         if (e_ready) begin
            e_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && c_ready) begin
         c_span_x_ff <= span_x_in;
         c_span_y_ff <= span_y_in;
         c_x_lo_ff   <= PIN_W'(in_lo_x);
         c_x_hi_ff   <= PIN_W'(in_hi_x);
         c_y_lo_ff   <= PIN_W'(in_lo_y);
         c_y_hi_ff   <= PIN_W'(in_hi_y);
         c_tag_ff    <= in_tag;
      end
      if (c_valid_ff && d_ready) begin
         d_wl_x_ff <= wl_x_in;
         d_wl_y_ff <= wl_y_in;
         d_x_lo_ff <= c_x_lo_ff;
         d_x_hi_ff <= c_x_hi_ff;
         d_y_lo_ff <= c_y_lo_ff;
         d_y_hi_ff <= c_y_hi_ff;
         d_tag_ff  <= c_tag_ff;
      end
      if (d_valid_ff && e_ready) begin
         e_wl_x_ff     <= d_wl_x_ff;
         e_wl_y_ff     <= d_wl_y_ff;
         e_wl_total_ff <= WL_SUM_W'(d_wl_x_ff) + WL_SUM_W'(d_wl_y_ff);
         e_x_lo_ff     <= d_x_lo_ff;
         e_x_hi_ff     <= d_x_hi_ff;
         e_y_lo_ff     <= d_y_lo_ff;
         e_y_hi_ff     <= d_y_hi_ff;
         e_tag_ff      <= d_tag_ff;
      end
   end

   assign rsp_valid       = e_valid_ff;
   assign rsp_x_lo        = e_x_lo_ff;
   assign rsp_x_hi        = e_x_hi_ff;
   assign rsp_y_lo        = e_y_lo_ff;
   assign rsp_y_hi        = e_y_hi_ff;
   assign rsp_wl_x        = e_wl_x_ff;
   assign rsp_wl_y        = e_wl_y_ff;
   assign rsp_wl_total    = e_wl_total_ff;
   assign rsp_max_x_index = e_tag_ff.max_x;
   assign rsp_min_x_index = e_tag_ff.min_x;
   assign rsp_max_y_index = e_tag_ff.max_y;
   assign rsp_min_y_index = e_tag_ff.min_y;
   assign rsp_pin_count   = e_tag_ff.count;

endmodule

`default_nettype wire

FILE: hdl/net_hpwl_bound_reducer.sv
// Weighted half-perimeter wirelength of a net. Pins stream in on the req_
// channel at one per cycle while the result side does not stall; the pin
// marked last closes the net and yields one rsp_ transaction after the pin
// register, extreme update, span, multiply-and-saturate and sum registers.
// The sustained rate of one pin per clock is set by the compare/update loop on
// the running extremes. Nets may follow each other back to back with no gap.
// weight (index 0, 8 fraction bits) and mode (index 1) are written through
// csr_, which is always ready; write them only while no net is in flight.
`default_nettype none

module net_hpwl_bound_reducer import nhbr_pkg::*; #(
   parameter int MAX_PINS   = DEF_MAX_PINS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [WEIGHT_W-1:0]     csr_data,

   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [PIN_W-1:0] req_pin_x,
   input  wire logic signed [PIN_W-1:0] req_pin_y,
   input  wire logic [HALF_W-1:0]       req_half_width,
   input  wire logic [HALF_W-1:0]       req_half_height,
   input  wire logic [COMP_W-1:0]       req_component_id,
   input  wire logic [COMP_W-1:0]       req_exclude_id,
   input  wire logic                    req_last,

   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [PIN_W-1:0]      rsp_x_lo,
   output logic signed [PIN_W-1:0]      rsp_x_hi,
   output logic signed [PIN_W-1:0]      rsp_y_lo,
   output logic signed [PIN_W-1:0]      rsp_y_hi,
   output logic [WL_W-1:0]              rsp_wl_x,
   output logic [WL_W-1:0]              rsp_wl_y,
   output logic [WL_SUM_W-1:0]          rsp_wl_total,
   output logic [IDX_W-1:0]             rsp_max_x_index,
   output logic [IDX_W-1:0]             rsp_min_x_index,
   output logic [IDX_W-1:0]             rsp_max_y_index,
   output logic [IDX_W-1:0]             rsp_min_y_index,
   output logic [COUNT_W-1:0]           rsp_pin_count
);

   logic [WEIGHT_W-1:0]          weight_ff;
   mode_type                     mode_ff;

   logic                         net_valid, net_ready;
   logic signed [COORD_BITS-1:0] net_lo_x, net_hi_x, net_lo_y, net_hi_y;
   tag_type                      net_tag;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
         mode_ff   <= MODE_PIN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WEIGHT: begin
               weight_ff <= csr_data;
            end
            CSR_MODE: begin
               mode_ff <= mode_type'(csr_data[MODE_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   nhbr_accum #(
      .MAX_PINS   (MAX_PINS),
      .COORD_BITS (COORD_BITS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .mode         (mode_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .pin_x        (req_pin_x),
      .pin_y        (req_pin_y),
      .pin_half_w   (req_half_width),
      .pin_half_h   (req_half_height),
      .component_id (req_component_id),
      .exclude_id   (req_exclude_id),
      .last         (req_last),
      .out_valid    (net_valid),
      .out_ready    (net_ready),
      .out_lo_x     (net_lo_x),
      .out_hi_x     (net_hi_x),
      .out_lo_y     (net_lo_y),
      .out_hi_y     (net_hi_y),
      .out_tag      (net_tag)
   );

   nhbr_weigh #(
      .COORD_BITS (COORD_BITS)
   ) u_weigh (
      .clock           (clock),
      .reset           (reset),
      .weight          (weight_ff),
      .in_valid        (net_valid),
      .in_ready        (net_ready),
      .in_lo_x         (net_lo_x),
      .in_hi_x         (net_hi_x),
      .in_lo_y         (net_lo_y),
      .in_hi_y         (net_hi_y),
      .in_tag          (net_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_lo        (rsp_x_lo),
      .rsp_x_hi        (rsp_x_hi),
      .rsp_y_lo        (rsp_y_lo),
      .rsp_y_hi        (rsp_y_hi),
      .rsp_wl_x        (rsp_wl_x),
      .rsp_wl_y        (rsp_wl_y),
      .rsp_wl_total    (rsp_wl_total),
      .rsp_max_x_index (rsp_max_x_index),
      .rsp_min_x_index (rsp_min_x_index),
      .rsp_max_y_index (rsp_max_y_index),
      .rsp_min_y_index (rsp_min_y_index),
      .rsp_pin_count   (rsp_pin_count)
   );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top import nhbr_pkg::*; ();

   localparam int RANDOM_PINS = 1400;
   localparam int CALM_MARK   = RANDOM_PINS * 85 / 100;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_PAUSE = 8;
   localparam int NET_PIN_CAP = DEF_MAX_PINS;

   localparam logic signed [PIN_W-1:0] COORD_TOP    = 32'sh7FFF_FFFF;
   localparam logic signed [PIN_W-1:0] COORD_BOTTOM = 32'sh8000_0000;
   localparam longint COORD_HI_L = (64'sd1 <<< (DEF_COORD_BITS - 1)) - 1;
   localparam longint COORD_LO_L = -COORD_HI_L - 1;
   localparam logic [63:0] WL_SAT = 64'h0000_FFFF_FFFF_FFFF;

   typedef enum int {SPREAD_WIDE, SPREAD_TIGHT, SPREAD_EDGE, SPREAD_LOCAL} spread_type;
   typedef enum int {HALF_NONE, HALF_SMALL, HALF_WIDE, HALF_FULL} half_size_type;

   typedef struct {
      logic signed [PIN_W-1:0] x;
      logic signed [PIN_W-1:0] y;
      logic [HALF_W-1:0]       hw;
      logic [HALF_W-1:0]       hh;
      logic [COMP_W-1:0]       cid;
      logic [COMP_W-1:0]       eid;
      logic                    last;
   } pin_type;

   typedef struct {
      logic signed [PIN_W-1:0] x_lo;
      logic signed [PIN_W-1:0] x_hi;
      logic signed [PIN_W-1:0] y_lo;
      logic signed [PIN_W-1:0] y_hi;
      logic [WL_W-1:0]         wl_x;
      logic [WL_W-1:0]         wl_y;
      logic [WL_SUM_W-1:0]     wl_total;
      logic [IDX_W-1:0]        max_x_idx;
      logic [IDX_W-1:0]        min_x_idx;
      logic [IDX_W-1:0]        max_y_idx;
      logic [IDX_W-1:0]        min_y_idx;
      logic [COUNT_W-1:0]      count;
   } net_result_type;

   typedef struct {
      mode_type            mode;
      logic [WEIGHT_W-1:0] weight;
      pin_type             pin;
      bit                  typed;
      net_result_type      res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [WEIGHT_W-1:0]     csr_data;

   logic                    req_valid;
   logic                    req_ready;
   logic signed [PIN_W-1:0] req_pin_x;
   logic signed [PIN_W-1:0] req_pin_y;
   logic [HALF_W-1:0]       req_half_width;
   logic [HALF_W-1:0]       req_half_height;
   logic [COMP_W-1:0]       req_component_id;
   logic [COMP_W-1:0]       req_exclude_id;
   logic                    req_last;

   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [PIN_W-1:0] rsp_x_lo;
   logic signed [PIN_W-1:0] rsp_x_hi;
   logic signed [PIN_W-1:0] rsp_y_lo;
   logic signed [PIN_W-1:0] rsp_y_hi;
   logic [WL_W-1:0]         rsp_wl_x;
   logic [WL_W-1:0]         rsp_wl_y;
   logic [WL_SUM_W-1:0]     rsp_wl_total;
   logic [IDX_W-1:0]        rsp_max_x_index;
   logic [IDX_W-1:0]        rsp_min_x_index;
   logic [IDX_W-1:0]        rsp_max_y_index;
   logic [IDX_W-1:0]        rsp_min_y_index;
   logic [COUNT_W-1:0]      rsp_pin_count;

   net_hpwl_bound_reducer uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_x        (req_pin_x),
      .req_pin_y        (req_pin_y),
      .req_half_width   (req_half_width),
      .req_half_height  (req_half_height),
      .req_component_id (req_component_id),
      .req_exclude_id   (req_exclude_id),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_x_lo         (rsp_x_lo),
      .rsp_x_hi         (rsp_x_hi),
      .rsp_y_lo         (rsp_y_lo),
      .rsp_y_hi         (rsp_y_hi),
      .rsp_wl_x         (rsp_wl_x),
      .rsp_wl_y         (rsp_wl_y),
      .rsp_wl_total     (rsp_wl_total),
      .rsp_max_x_index  (rsp_max_x_index),
      .rsp_min_x_index  (rsp_min_x_index),
      .rsp_max_y_index  (rsp_max_y_index),
      .rsp_min_y_index  (rsp_min_y_index),
      .rsp_pin_count    (rsp_pin_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [WEIGHT_W-1:0] cur_weight;
   mode_type            cur_mode;
   longint              run_lo_x, run_hi_x, run_lo_y, run_hi_y;
   logic [IDX_W-1:0]    first_at[4];
   int                  pins_in_net;
   bit                  any_kept;

   net_result_type net_results_q[$];
   stim_row_type   directed_rows[$];
   net_result_type unchecked = '{default: '0};

   int mismatch_count = 0;
   int result_no = 0;
   int stall_cycles = 0;
   int send_gap_pct = 0;
   bit calm = 1'b0;

   mode_type            phase_modes[6]   = '{MODE_PIN, MODE_BBOX, MODE_CENTER,
                                             MODE_EXCLUDE, MODE_EXCLUDE, MODE_BBOX};
   logic [WEIGHT_W-1:0] phase_weights[6] = '{16'd0, 16'hFFFF, 16'd1,
                                             16'hFFFF, 16'd0, 16'd256};

   task automatic clear_net_state();
      run_lo_x = 0;
      run_hi_x = 0;
      run_lo_y = 0;
      run_hi_y = 0;
      for (int i = 0; i < 4; i++) first_at[i] = '0;
      pins_in_net = 0;
      any_kept = 1'b0;
   endtask

   function automatic longint clamp_coord(longint v);
      if (v > COORD_HI_L) return COORD_HI_L;
      if (v < COORD_LO_L) return COORD_LO_L;
      return v;
   endfunction

   function automatic logic [WL_W-1:0] weigh_span(longint lo, longint hi);
      logic [63:0] span;
      logic [63:0] prod;
      span = hi - lo;
      if (cur_weight != 0 && span > WL_SAT / cur_weight) return WL_SAT[WL_W-1:0];
      prod = span * cur_weight;
      return prod[WL_W-1:0];
   endfunction

   // Folds one pin into the running extremes; on the last pin yields the net's result.
   task automatic fold_pin(input pin_type p, output bit emits, output net_result_type r);
      longint x, y, hw, hh, lx, hx, ly, hy, xl, xh, yl, yh;
      logic [IDX_W-1:0] pos;
      bit keep;
      int n;
      x = p.x;
      y = p.y;
      hw = (cur_mode == MODE_BBOX) ? longint'(p.hw) : 64'sd0;
      hh = (cur_mode == MODE_BBOX) ? longint'(p.hh) : 64'sd0;
      n = (pins_in_net < NET_PIN_CAP) ? pins_in_net : NET_PIN_CAP - 1;
      pos = n[IDX_W-1:0];
      keep = (cur_mode != MODE_EXCLUDE) || (p.cid != p.eid);
      r = '{default: '0};
      emits = p.last;
      if (keep) begin
         lx = clamp_coord(x - hw);
         hx = clamp_coord(x + hw);
         ly = clamp_coord(y - hh);
         hy = clamp_coord(y + hh);
         if (!any_kept) begin
            run_lo_x = lx;
            run_hi_x = hx;
            run_lo_y = ly;
            run_hi_y = hy;
            for (int i = 0; i < 4; i++) first_at[i] = pos;
            any_kept = 1'b1;
         end else begin
            // strict compares: the first pin at an extreme keeps it
            if (hx > run_hi_x) begin run_hi_x = hx; first_at[0] = pos; end
            if (lx < run_lo_x) begin run_lo_x = lx; first_at[1] = pos; end
            if (hy > run_hi_y) begin run_hi_y = hy; first_at[2] = pos; end
            if (ly < run_lo_y) begin run_lo_y = ly; first_at[3] = pos; end
         end
      end
      if (pins_in_net < NET_PIN_CAP) pins_in_net++;
      if (!p.last) return;

      n = pins_in_net;
      if (!any_kept || (cur_mode == MODE_EXCLUDE && n == 1)) begin
         xl = COORD_LO_L;
         yl = COORD_LO_L;
         xh = COORD_HI_L;
         yh = COORD_HI_L;
      end else begin
         xl = run_lo_x;
         xh = run_hi_x;
         yl = run_lo_y;
         yh = run_hi_y;
         if (n > 1) begin
            r.wl_x = weigh_span(xl, xh);
            r.wl_y = weigh_span(yl, yh);
            r.max_x_idx = first_at[0];
            r.min_x_idx = first_at[1];
            r.max_y_idx = first_at[2];
            r.min_y_idx = first_at[3];
            // pin mode repairs the indices of a degenerate axis
            if (cur_mode == MODE_PIN && xl == xh) begin
               r.max_x_idx = IDX_W'(0);
               r.min_x_idx = IDX_W'(1);
            end
            if (cur_mode == MODE_PIN && yl == yh) begin
               r.max_y_idx = IDX_W'(0);
               r.min_y_idx = IDX_W'(1);
            end
         end
      end
      r.x_lo = xl[PIN_W-1:0];
      r.x_hi = xh[PIN_W-1:0];
      r.y_lo = yl[PIN_W-1:0];
      r.y_hi = yh[PIN_W-1:0];
      r.wl_total = {1'b0, r.wl_x} + {1'b0, r.wl_y};
      r.count = n[COUNT_W-1:0];
      clear_net_state();
   endtask

   task automatic flag_error(string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         flag_error($sformatf("result %0d: %s = %h, expected %h", result_no, name, got, want));
   endtask

   always @(posedge clock) begin : rsp_monitor
      net_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (net_results_q.size() == 0) begin
            flag_error($sformatf("result %0d arrived with none pending", result_no));
         end else begin
            want = net_results_q.pop_front();
            check_field("x_lo", 64'(rsp_x_lo), 64'(want.x_lo));
            check_field("x_hi", 64'(rsp_x_hi), 64'(want.x_hi));
            check_field("y_lo", 64'(rsp_y_lo), 64'(want.y_lo));
            check_field("y_hi", 64'(rsp_y_hi), 64'(want.y_hi));
            check_field("wl_x", 64'(rsp_wl_x), 64'(want.wl_x));
            check_field("wl_y", 64'(rsp_wl_y), 64'(want.wl_y));
            check_field("wl_total", 64'(rsp_wl_total), 64'(want.wl_total));
            check_field("max_x_index", 64'(rsp_max_x_index), 64'(want.max_x_idx));
            check_field("min_x_index", 64'(rsp_min_x_index), 64'(want.min_x_idx));
            check_field("max_y_index", 64'(rsp_max_y_index), 64'(want.max_y_idx));
            check_field("min_y_index", 64'(rsp_min_y_index), 64'(want.min_y_idx));
            check_field("pin_count", 64'(rsp_pin_count), 64'(want.count));
         end
         result_no++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("ERROR @%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result-side backpressure in random bursts
   initial begin
      int span;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
            span = $urandom_range(1, 14);
            repeat (span - 1) @(negedge clock);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_pin(input pin_type p, input bit typed, input net_result_type typed_res);
      bit emits;
      net_result_type r;
      if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_pin_x        <= p.x;
      req_pin_y        <= p.y;
      req_half_width   <= p.hw;
      req_half_height  <= p.hh;
      req_component_id <= p.cid;
      req_exclude_id   <= p.eid;
      req_last         <= p.last;
      do @(posedge clock); while (!req_ready);
      fold_pin(p, emits, r);
      if (emits) begin
         if (typed) r = typed_res;
         net_results_q = {net_results_q, r};
      end
      @(negedge clock);
   endtask

   // Registers change only with the block drained and quiet.
   task automatic apply_config(input mode_type m, input logic [WEIGHT_W-1:0] w);
      req_valid <= 1'b0;
      while (net_results_q.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_WEIGHT;
      csr_data  <= w;
      do @(posedge clock); while (!csr_ready);
      cur_weight = w;
      @(negedge clock);
      csr_index <= CSR_MODE;
      csr_data  <= {{(WEIGHT_W - MODE_W){1'b0}}, m};
      do @(posedge clock); while (!csr_ready);
      cur_mode = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(input mode_type m, input logic [WEIGHT_W-1:0] w,
                          input logic signed [PIN_W-1:0] x, y,
                          input logic [HALF_W-1:0] hw, hh,
                          input logic [COMP_W-1:0] cid, eid, input logic last,
                          input bit typed, input net_result_type res);
      stim_row_type row;
      row.mode   = m;
      row.weight = w;
      row.pin    = '{x, y, hw, hh, cid, eid, last};
      row.typed  = typed;
      row.res    = res;
      directed_rows = {directed_rows, row};
   endtask

   function automatic net_result_type mk_res(
         logic signed [PIN_W-1:0] xl, xh, yl, yh, logic [WL_W-1:0] wx, wy,
         logic [WL_SUM_W-1:0] wt, logic [IDX_W-1:0] i0, i1, i2, i3,
         logic [COUNT_W-1:0] n);
      net_result_type r;
      r = '{xl, xh, yl, yh, wx, wy, wt, i0, i1, i2, i3, n};
      return r;
   endfunction

   function automatic logic signed [PIN_W-1:0] pick_coord(spread_type s,
                                                          logic signed [PIN_W-1:0] base);
      case (s)
         SPREAD_TIGHT: return base + $urandom_range(0, 3);
         SPREAD_LOCAL: return base + $urandom_range(0, 4095);
         SPREAD_EDGE: begin
            case ($urandom_range(0, 4))
               0: return COORD_BOTTOM;
               1: return COORD_TOP;
               2: return '0;
               3: return '1;
               default: return $urandom;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [HALF_W-1:0] pick_half(half_size_type h);
      logic [31:0] raw;
      raw = $urandom;
      case (h)
         HALF_NONE:  return '0;
         HALF_SMALL: return HALF_W'(raw[7:0]);
         HALF_FULL:  return '1;
         default:    return raw[HALF_W-1:0];
      endcase
   endfunction

   function automatic logic [COMP_W-1:0] pick_id();
      logic [31:0] raw;
      raw = $urandom;
      if ($urandom_range(0, 1) == 0) return COMP_W'($urandom_range(0, 3));
      return raw[COMP_W-1:0];
   endfunction

   int sent_random = 0;
   int long_nets = 0;

   task automatic send_net();
      int len;
      int pick;
      spread_type spread;
      half_size_type hk;
      logic signed [PIN_W-1:0] bx, by;
      logic [COMP_W-1:0] eid;
      bit drop_all;
      pin_type p;
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 1;
      else if (pick < 70) len = $urandom_range(2, 6);
      else if (pick < 95) len = $urandom_range(7, 30);
      else len = $urandom_range(31, 80);
      // up to two nets run past the pin counter's ceiling
      if (long_nets < 2 && $urandom_range(0, 59) == 0) begin
         len = $urandom_range(NET_PIN_CAP + 1, NET_PIN_CAP + 14);
         long_nets++;
      end
      spread = spread_type'($urandom_range(0, 3));
      hk = half_size_type'($urandom_range(0, 3));
      bx = $urandom;
      by = $urandom;
      eid = pick_id();
      drop_all = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
         p.x    = pick_coord(spread, bx);
         p.y    = pick_coord(spread, by);
         p.hw   = pick_half(hk);
         p.hh   = pick_half(hk);
         p.eid  = eid;
         p.cid  = (drop_all || $urandom_range(0, 3) == 0) ? eid : pick_id();
         p.last = (i == len - 1);
         send_pin(p, 1'b0, unchecked);
         sent_random++;
      end
   endtask

   initial begin
      bit net_open;
      int phase;
      int phase_end;
      mode_type m;
      logic [WEIGHT_W-1:0] w;
      logic [31:0] raw;

      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_index        = CSR_WEIGHT;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_pin_x        = '0;
      req_pin_y        = '0;
      req_half_width   = '0;
      req_half_height  = '0;
      req_component_id = '0;
      req_exclude_id   = '0;
      req_last         = 1'b0;
      cur_weight       = WEIGHT_RESET;
      cur_mode         = MODE_PIN;
      clear_net_state();

      // single pin right after reset
      add_row(MODE_PIN, 16'd256, 5, -7, 0, 0, 1, 2, 1'b1, 1'b1,
              mk_res(5, 5, -7, -7, 0, 0, 0, 0, 0, 0, 0, 1));
      // all pins coincide: tie repair on both axes, half sizes ignored
      add_row(MODE_PIN, 16'd256, 100, 200, '1, '1, 0, 0, 1'b0, 1'b0, unchecked);
      add_row(MODE_PIN, 16'd256, 100, 200, '1, '1, 0, 0, 1'b0, 1'b0, unchecked);
      add_row(MODE_PIN, 16'd256, 100, 200, '1, '1, 0, 0, 1'b1, 1'b0, unchecked);
      // widest span at the largest weight
      add_row(MODE_PIN, 16'hFFFF, COORD_TOP, COORD_TOP, 0, 0, 0, 0, 1'b0, 1'b0, unchecked);
      add_row(MODE_PIN, 16'hFFFF, COORD_BOTTOM, COORD_BOTTOM, 0, 0, 0, 0, 1'b1, 1'b1,
              mk_res(COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, COORD_TOP,
                     48'hFFFE_FFFF_0001, 48'hFFFE_FFFF_0001, 49'h1_FFFD_FFFE_0002,
                     0, 1, 0, 1, 2));
      // pin boxes pushed past the coordinate range
      add_row(MODE_BBOX, 16'd256, 32'sh7FFF_FFFA, 32'sh8000_0003, '1, '1, 9, 9,
              1'b0, 1'b0, unchecked);
      add_row(MODE_BBOX, 16'd256, 32'sh8000_0003, 32'sh7FFF_FFFA, '1, 0, 9, 9,
              1'b1, 1'b0, unchecked);
      // center mode leaves ties alone; zero weight
      add_row(MODE_CENTER, 16'd0, -1, -1, 0, 0, 0, 0, 1'b0, 1'b0, unchecked);
      add_row(MODE_CENTER, 16'd0, -1, -1, 0, 0, 0, 0, 1'b1, 1'b0, unchecked);
      // exclude mode, one pin: sentinel bounds
      add_row(MODE_EXCLUDE, 16'd128, 7, 8, 0, 0, 3, 4, 1'b1, 1'b1,
              mk_res(COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, COORD_TOP, 0, 0, 0,
                     0, 0, 0, 0, 1));
      // exclude mode, every pin dropped
      add_row(MODE_EXCLUDE, 16'd128, 11, 12, 0, 0, '1, '1, 1'b0, 1'b0, unchecked);
      add_row(MODE_EXCLUDE, 16'd128, -11, -12, 0, 0, '1, '1, 1'b1, 1'b1,
              mk_res(COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, COORD_TOP, 0, 0, 0,
                     0, 0, 0, 0, 2));
      // dropped first pin: kept indices start at 1
      add_row(MODE_EXCLUDE, 16'd128, 10, 10, 0, 0, '1, '1, 1'b0, 1'b0, unchecked);
      add_row(MODE_EXCLUDE, 16'd128, -20, 30, 0, 0, 0, '1, 1'b0, 1'b0, unchecked);
      add_row(MODE_EXCLUDE, 16'd128, 40, -50, 0, 0, 1, '1, 1'b1, 1'b0, unchecked);
      // alternating bit patterns through every field
      add_row(MODE_BBOX, 16'd1, 32'sh5555_5555, 32'shAAAA_AAAA, 30'h2AAA_AAAA,
              30'h1555_5555, 16'hAAAA, 16'h5555, 1'b0, 1'b0, unchecked);
      add_row(MODE_BBOX, 16'd1, 32'shAAAA_AAAA, 32'sh5555_5555, 30'h1555_5555,
              30'h2AAA_AAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0, unchecked);
      // later pins at an existing extreme keep the earlier index
      add_row(MODE_PIN, 16'd256, 3, 1, 0, 0, 0, 0, 1'b0, 1'b0, unchecked);
      add_row(MODE_PIN, 16'd256, 9, 1, 0, 0, 0, 0, 1'b0, 1'b0, unchecked);
      add_row(MODE_PIN, 16'd256, 9, -4, 0, 0, 0, 0, 1'b1, 1'b0, unchecked);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_gap_pct = 20;
      net_open = 1'b0;
      foreach (directed_rows[i]) begin
         if (!net_open && (directed_rows[i].mode != cur_mode ||
                           directed_rows[i].weight != cur_weight))
            apply_config(directed_rows[i].mode, directed_rows[i].weight);
         send_pin(directed_rows[i].pin, directed_rows[i].typed, directed_rows[i].res);
         net_open = !directed_rows[i].pin.last;
      end

      phase = 0;
      while (sent_random < RANDOM_PINS) begin
         if (phase < 6) begin
            m = phase_modes[phase];
            w = phase_weights[phase];
         end else begin
            m = mode_type'($urandom_range(0, 3));
            raw = $urandom;
            case ($urandom_range(0, 3))
               0: w = '0;
               1: w = '1;
               default: w = raw[WEIGHT_W-1:0];
            endcase
         end
         apply_config(m, w);
         case ($urandom_range(0, 2))
            0: send_gap_pct = 0;
            1: send_gap_pct = 10;
            default: send_gap_pct = 35;
         endcase
         phase_end = sent_random + $urandom_range(60, 160);
         while (sent_random < phase_end && sent_random < RANDOM_PINS) begin
            calm = (sent_random >= CALM_MARK);
            send_net();
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (net_results_q.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
